// ===== rtl/core/lfu_pkg.sv =====
// lfu_pkg: shared widths, codes and state type of the lfu cache table
// used by the channel interfaces and the core; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lfu_pkg;

  localparam int unsigned KeyW = 31;
  localparam int unsigned ValW = 31;
  localparam int unsigned CntW = 32;
  localparam int unsigned CapW = 5;

  // default table size and register reset value
  localparam int unsigned CapacityDefault = 16;
  localparam logic [CapW-1:0] CapReset = 5'd16;

  // operation codes
  localparam logic OpGet = 1'b0;
  localparam logic OpPut = 1'b1;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StDecide,
    StUpdate,
    StResp
  } lfu_state_e;

endpackage

`default_nettype wire

// ===== rtl/core/lfu_req_if.sv =====
// lfu_req_if: request channel (op, key, value) with valid/ready
// depends on lfu_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface lfu_req_if;
  logic                     valid;
  logic                     ready;
  logic                     op;
  logic [lfu_pkg::KeyW-1:0] key;
  logic [lfu_pkg::ValW-1:0] value;

  modport source (output valid, output op, output key, output value, input ready);
  modport sink (input valid, input op, input key, input value, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lfu_rsp_if.sv =====
// lfu_rsp_if: response channel (hit, value_out) with valid/ready
// depends on lfu_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface lfu_rsp_if;
  logic                     valid;
  logic                     ready;
  logic                     hit;
  logic [lfu_pkg::ValW-1:0] value_out;

  modport source (output valid, output hit, output value_out, input ready);
  modport sink (input valid, input hit, input value_out, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lfu_cfg_if.sv =====
// lfu_cfg_if: configuration write channel carrying the capacity register
// depends on lfu_pkg for the register width
`timescale 1ns / 1ps
`default_nettype none

interface lfu_cfg_if;
  logic                     valid;
  logic                     ready;
  logic [lfu_pkg::CapW-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lfu_ram.sv =====
// lfu_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module lfu_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/lfu_cache_table_core.sv =====
// lfu_cache_table_core: fully associative key/value cache, lfu replacement, lru tie-break
// depends on lfu_pkg, lfu_req_if, lfu_rsp_if, lfu_cfg_if and lfu_ram
`timescale 1ns / 1ps
`default_nettype none

// One request is handled at a time. Each entry (key, value, use count, recency rank)
// lives in a single-port-read ram word; valid bits and the occupancy count sit in
// flip-flops and clear at reset, so no clearing pass is needed. A request sweeps the
// ram once to find the key, the eviction victim and the first free slot, then (for a
// get hit or any put) sweeps it a second time, writing back aged recency ranks and
// the new entry. The response register is loaded from the response state after the
// scan sweep and the decide state for a get miss, after the update sweep for a get
// hit or a put, and with no sweep at all for a request with capacity zero; the
// response state waits for a full response register to drain, and the next request
// is taken in the idle state after it. The sweeps are paced by the single ram read
// port, one entry per cycle per sweep. A new request is taken while the previous
// response still waits in the output register. The capacity register may only be
// written while no request is in flight.

module lfu_cache_table_core #(
  parameter int unsigned CAPACITY = lfu_pkg::CapacityDefault
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  lfu_req_if.sink   req_i,
  lfu_rsp_if.source rsp_o,
  lfu_cfg_if.sink   cfg_i
);

  localparam int unsigned IdxW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned RankW = IdxW;
  localparam int unsigned OccW  = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW  = (OccW > lfu_pkg::CapW) ? OccW : lfu_pkg::CapW;
  localparam int unsigned WordW = lfu_pkg::KeyW + lfu_pkg::ValW + lfu_pkg::CntW + RankW;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(CAPACITY - 1);
  localparam logic [lfu_pkg::CntW-1:0] CntMax = '1;

  // ram word layout: key | value | count | rank
  function automatic logic [WordW-1:0] pack_word(
    input logic [lfu_pkg::KeyW-1:0] key,
    input logic [lfu_pkg::ValW-1:0] val,
    input logic [lfu_pkg::CntW-1:0] cnt,
    input logic [RankW-1:0]         rank
  );
    pack_word = {key, val, cnt, rank};
  endfunction

  // ---------------------------------------------------------------------------
  // state
  // ---------------------------------------------------------------------------
  lfu_pkg::lfu_state_e state_q, state_d;

  logic [lfu_pkg::CapW-1:0] capacity_q;
  logic [CAPACITY-1:0]      valid_q;
  logic [OccW-1:0]          occ_q;

  // latched request
  logic                     op_q;
  logic [lfu_pkg::KeyW-1:0] key_q;
  logic [lfu_pkg::ValW-1:0] val_q;

  // ram sweep sequencer: issue address and its registered copy, the processing index
  logic [IdxW-1:0] addr_q;
  logic            iss_done_q;
  logic            pend_q;
  logic [IdxW-1:0] pidx_q;

  // scan results
  logic                     hit_q;
  logic [IdxW-1:0]          hslot_q;
  logic [lfu_pkg::ValW-1:0] hval_q;
  logic [lfu_pkg::CntW-1:0] hcnt_q;
  logic [RankW-1:0]         hrank_q;
  logic                     vfound_q;
  logic [IdxW-1:0]          vslot_q;
  logic [lfu_pkg::CntW-1:0] vcnt_q;
  logic [RankW-1:0]         vrank_q;
  logic                     ffound_q;
  logic [IdxW-1:0]          fslot_q;

  // decided update
  logic             drop_en_q;
  logic [RankW-1:0] drop_r_q;
  logic [IdxW-1:0]  slot_q;
  logic [WordW-1:0] new_word_q;

  // response register
  logic                     out_valid_q;
  logic                     out_hit_q;
  logic [lfu_pkg::ValW-1:0] out_val_q;

  // ---------------------------------------------------------------------------
  // ram
  // ---------------------------------------------------------------------------
  logic             ram_we;
  logic [WordW-1:0] ram_wdata;
  logic             ram_re;
  logic [WordW-1:0] ram_rdata;

  lfu_ram #(
    .Width (WordW),
    .Depth (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (pidx_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (addr_q),
    .rdata_o (ram_rdata)
  );

  // read word fields
  logic [lfu_pkg::KeyW-1:0] rd_key;
  logic [lfu_pkg::ValW-1:0] rd_val;
  logic [lfu_pkg::CntW-1:0] rd_cnt;
  logic [RankW-1:0]         rd_rank;

  assign {rd_key, rd_val, rd_cnt, rd_rank} = ram_rdata;

  // ---------------------------------------------------------------------------
  // derived control
  // ---------------------------------------------------------------------------
  logic [CmpW-1:0] cap_ext;
  logic [CmpW-1:0] cap_eff;
  logic [CmpW-1:0] occ_ext;
  logic            cap_zero;
  logic            need_evict;
  logic            req_fire;
  logic            pass_last;
  logic            rsp_free;
  logic            p_valid;

  assign cap_ext    = CmpW'(capacity_q);
  assign cap_eff    = (cap_ext > CmpW'(CAPACITY)) ? CmpW'(CAPACITY) : cap_ext;
  assign occ_ext    = CmpW'(occ_q);
  assign cap_zero   = (capacity_q == '0);
  assign need_evict = (occ_ext >= cap_eff);
  assign req_fire   = req_i.valid && req_i.ready;
  assign pass_last  = pend_q && (pidx_q == LastIdx);
  assign rsp_free   = !out_valid_q || rsp_o.ready;
  assign p_valid    = valid_q[pidx_q];

  // ---------------------------------------------------------------------------
  // next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      lfu_pkg::StIdle: begin
        if (req_fire) begin
          // disabled cache answers a miss straight away
          state_d = cap_zero ? lfu_pkg::StResp : lfu_pkg::StScan;
        end
      end
      lfu_pkg::StScan: begin
        if (pass_last) begin
          state_d = lfu_pkg::StDecide;
        end
      end
      lfu_pkg::StDecide: begin
        // get miss leaves the table untouched
        if (!hit_q && (op_q == lfu_pkg::OpGet)) begin
          state_d = lfu_pkg::StResp;
        end else begin
          state_d = lfu_pkg::StUpdate;
        end
      end
      lfu_pkg::StUpdate: begin
        if (pass_last) begin
          state_d = lfu_pkg::StResp;
        end
      end
      lfu_pkg::StResp: begin
        if (rsp_free) begin
          state_d = lfu_pkg::StIdle;
        end
      end
      default: state_d = lfu_pkg::StIdle;
    endcase
  end

  // ---------------------------------------------------------------------------
  // outputs and ram control
  // ---------------------------------------------------------------------------
  always_comb begin
    req_i.ready = 1'b0;
    ram_re      = 1'b0;
    ram_we      = 1'b0;
    ram_wdata   = new_word_q;
    case (state_q)
      lfu_pkg::StIdle: begin
        req_i.ready = 1'b1;
      end
      lfu_pkg::StScan: begin
        ram_re = !iss_done_q;
      end
      lfu_pkg::StUpdate: begin
        ram_re = !iss_done_q;
        if (pend_q) begin
          if (pidx_q == slot_q) begin
            // the touched or newly inserted entry
            ram_we    = 1'b1;
            ram_wdata = new_word_q;
          end else if (drop_en_q && p_valid && (rd_rank > drop_r_q)) begin
            // younger entries move one place down the recency order
            ram_we    = 1'b1;
            ram_wdata = pack_word(rd_key, rd_val, rd_cnt, rd_rank - RankW'(1));
          end
        end
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  assign cfg_i.ready     = 1'b1;
  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.hit       = out_hit_q;
  assign rsp_o.value_out = out_val_q;

  // ---------------------------------------------------------------------------
  // control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lfu_pkg::StIdle;
      capacity_q  <= lfu_pkg::CapReset;
      valid_q     <= '0;
      occ_q       <= '0;
      iss_done_q  <= 1'b0;
      pend_q      <= 1'b0;
      addr_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_i.valid && cfg_i.ready) begin
        capacity_q <= cfg_i.data;
      end

      // sweep sequencer, restarted on entry to either pass
      if ((state_q == lfu_pkg::StIdle) || (state_q == lfu_pkg::StDecide)) begin
        addr_q     <= '0;
        iss_done_q <= 1'b0;
        pend_q     <= 1'b0;
      end else begin
        pend_q <= ram_re;
        if (ram_re) begin
          addr_q <= addr_q + IdxW'(1);
          if (addr_q == LastIdx) begin
            iss_done_q <= 1'b1;
          end
        end
      end

      // insertion without eviction grows the table; eviction reuses the victim slot
      if ((state_q == lfu_pkg::StDecide) && !hit_q && (op_q == lfu_pkg::OpPut)) begin
        valid_q[need_evict ? vslot_q : fslot_q] <= 1'b1;
        if (!need_evict) begin
          occ_q <= occ_q + OccW'(1);
        end
      end

      if ((state_q == lfu_pkg::StResp) && rsp_free) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // scan results and payload
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q    <= 1'b0;
      vfound_q <= 1'b0;
      ffound_q <= 1'b0;
    end else if (req_fire) begin
      hit_q    <= 1'b0;
      vfound_q <= 1'b0;
      ffound_q <= 1'b0;
    end else if ((state_q == lfu_pkg::StScan) && pend_q) begin
      if (p_valid) begin
        if (!hit_q && (rd_key == key_q)) begin
          hit_q <= 1'b1;
        end
        if (!vfound_q || (rd_cnt < vcnt_q) || ((rd_cnt == vcnt_q) && (rd_rank < vrank_q))) begin
          vfound_q <= 1'b1;
        end
      end else if (!ffound_q) begin
        ffound_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      op_q  <= req_i.op;
      key_q <= req_i.key;
      val_q <= req_i.value;
    end

    pidx_q <= addr_q;

    if ((state_q == lfu_pkg::StScan) && pend_q) begin
      if (p_valid) begin
        if (!hit_q && (rd_key == key_q)) begin
          hslot_q <= pidx_q;
          hval_q  <= rd_val;
          hcnt_q  <= rd_cnt;
          hrank_q <= rd_rank;
        end
        // lowest count, then oldest use
        if (!vfound_q || (rd_cnt < vcnt_q) || ((rd_cnt == vcnt_q) && (rd_rank < vrank_q))) begin
          vslot_q <= pidx_q;
          vcnt_q  <= rd_cnt;
          vrank_q <= rd_rank;
        end
      end else if (!ffound_q) begin
        fslot_q <= pidx_q;
      end
    end

    if (state_q == lfu_pkg::StDecide) begin
      if (hit_q) begin
        drop_en_q  <= 1'b1;
        drop_r_q   <= hrank_q;
        slot_q     <= hslot_q;
        new_word_q <= pack_word(key_q, (op_q == lfu_pkg::OpPut) ? val_q : hval_q,
                                (hcnt_q == CntMax) ? hcnt_q : hcnt_q + lfu_pkg::CntW'(1),
                                RankW'(occ_q - OccW'(1)));
      end else if (need_evict) begin
        drop_en_q  <= 1'b1;
        drop_r_q   <= vrank_q;
        slot_q     <= vslot_q;
        new_word_q <= pack_word(key_q, val_q, lfu_pkg::CntW'(1), RankW'(occ_q - OccW'(1)));
      end else begin
        drop_en_q  <= 1'b0;
        drop_r_q   <= vrank_q;
        slot_q     <= fslot_q;
        new_word_q <= pack_word(key_q, val_q, lfu_pkg::CntW'(1), RankW'(occ_q));
      end
    end

    if ((state_q == lfu_pkg::StResp) && rsp_free) begin
      // a disabled cache never scanned, so its hit flag is still clear
      out_hit_q <= hit_q;
      out_val_q <= (hit_q && (op_q == lfu_pkg::OpGet)) ? hval_q : '0;
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_occ_matches_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(occ_q))
    else $error("occupancy count differs from number of valid entries");

  a_occ_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(occ_q) <= int'(CAPACITY))
    else $error("occupancy above table size");

  a_write_in_update : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == lfu_pkg::StUpdate))
    else $error("ram written outside the update sweep");

  a_rsp_from_resp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == lfu_pkg::StResp))
    else $error("response raised without a finished transaction");

endmodule

`default_nettype wire
